// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in %m");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed in %m");

`endif

// ----- hw/rtl/bums_pkg.sv -----
// ----------------------------------------------------------------------------
// Bottom-up merge sorter package
// Sizes and types shared by the sorter modules and its checker.
// ----------------------------------------------------------------------------
package bums_pkg;

    localparam int BLOCK_SIZE = 8;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(BLOCK_SIZE);
    localparam int CNT_W      = $clog2(BLOCK_SIZE + 1);
    localparam int SPAN_W     = CNT_W + 2;

    localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(BLOCK_SIZE - 1);
    localparam logic [SPAN_W-1:0] N_SPAN   = SPAN_W'(BLOCK_SIZE);

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        data_t value;
        logic  last;
    } out_item_t;

endpackage

// ----- hw/rtl/bottom_up_merge_sorter.sv -----
// Timing: the last value of a block passes through the input queue, the load,
// the merge passes and the emit read before its first result is queued.
// Blocks: a new block is loaded only after the last one has been emitted,
// and each merge step passes through a read state and a merge state, as the
// store reads are registered.
// Reset: asynchronous, active low; queues empty, the sorter waits for a load.
// ----------------------------------------------------------------------------
// Bottom-up merge sorter
// Collects blocks of BLOCK_SIZE signed values and returns each block sorted
// in ascending order, marking the final element of the block.
// ----------------------------------------------------------------------------
module bottom_up_merge_sorter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  bums_pkg::data_t value,
    output logic            empty,
    input  logic            pop,
    output bums_pkg::data_t sorted_value,
    output logic            last
);

    // The front queue decouples input transactions from the back end, which
    // stalls on input only while it is loading a block.
    logic                q_valid, q_pop;
    bums_pkg::data_t     q_data;

    // Results leave through a second queue, so the back end stalls only when
    // that queue is full.
    logic                oq_push, oq_full;
    bums_pkg::out_item_t oq_item;

    bums_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .value   (value),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    // The back end loads N values into one store and then merges runs of
    // doubling width, alternating between two stores, before it emits.
    bums_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .oq_push (oq_push),
        .oq_item (oq_item),
        .oq_full (oq_full)
    );

    bums_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_push       (oq_push),
        .q_item       (oq_item),
        .q_full       (oq_full),
        .empty        (empty),
        .pop          (pop),
        .sorted_value (sorted_value),
        .last         (last)
    );

endmodule

// ----- hw/rtl/bums_front.sv -----
// ----------------------------------------------------------------------------
// Sorter input queue
// Two-entry queue that takes input transactions while the back end is busy.
// ----------------------------------------------------------------------------
module bums_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  bums_pkg::data_t value,
    output logic            q_valid,
    output bums_pkg::data_t q_data,
    input  logic            q_pop
);

    bums_pkg::data_t buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = buf_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wr_ptr_reg] <= value;
        end
    end

endmodule

// ----- hw/rtl/bums_out.sv -----
// ----------------------------------------------------------------------------
// Sorter result queue
// Two-entry queue that holds sorted results until they are taken.
// ----------------------------------------------------------------------------
module bums_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_push,
    input  bums_pkg::out_item_t q_item,
    output logic                q_full,
    output logic                empty,
    input  logic                pop,
    output bums_pkg::data_t     sorted_value,
    output logic                last
);

    bums_pkg::out_item_t buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       do_push, do_pop;

    assign q_full       = (cnt_reg == 2'd2);
    assign empty        = (cnt_reg == 2'd0);
    assign sorted_value = buf_reg[rd_ptr_reg].value;
    assign last         = buf_reg[rd_ptr_reg].last;
    assign do_push      = q_push && !q_full;
    assign do_pop       = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wr_ptr_reg] <= q_item;
        end
    end

endmodule

// ----- hw/rtl/bums_core.sv -----
// ----------------------------------------------------------------------------
// Sorter back end
// Loads a block, merge-sorts it between two stores and emits it in order.
// ----------------------------------------------------------------------------
module bums_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  bums_pkg::data_t     q_data,
    output logic                q_pop,
    output logic                oq_push,
    output bums_pkg::out_item_t oq_item,
    input  logic                oq_full
);

    typedef enum logic [5:0] {
        ST_LOAD    = 6'b000001,
        ST_SETUP   = 6'b000010,
        ST_READ    = 6'b000100,
        ST_MERGE   = 6'b001000,
        ST_EMIT_RD = 6'b010000,
        ST_EMIT    = 6'b100000
    } state_t;

    localparam int SW = bums_pkg::SPAN_W;
    localparam int IW = bums_pkg::IDX_W;
    localparam int CW = bums_pkg::CNT_W;

    state_t state_reg, state_next;
    logic          src_sel_reg, src_sel_next;
    logic [SW-1:0] width_reg, width_next;
    logic [SW-1:0] lo_reg, lo_next, mid_reg, mid_next, hi_reg, hi_next;
    logic [SW-1:0] l_reg, l_next, r_reg, r_next, out_reg, out_next;
    logic [CW-1:0] load_cnt_reg, load_cnt_next, emit_cnt_reg, emit_cnt_next;

    bums_pkg::data_t mem_a [bums_pkg::BLOCK_SIZE];
    bums_pkg::data_t mem_b [bums_pkg::BLOCK_SIZE];
    bums_pkg::data_t a_l_reg, a_r_reg, b_l_reg, b_r_reg;
    bums_pkg::data_t dl, dr, wr_data;
    logic [IW-1:0]   rd_l_addr, rd_r_addr, wr_addr;
    logic            wr_a, wr_b, take_l;
    logic [SW-1:0]   lo_step, width_dbl, mid_raw, hi_raw;

    // Addresses past the block are never used; they are folded to zero.
    function automatic logic [IW-1:0] to_idx(input logic [SW-1:0] v);
        logic [IW-1:0] idx;
        idx = (v < bums_pkg::N_SPAN) ? v[IW-1:0] : '0;
        return idx;
    endfunction

    assign dl = src_sel_reg ? b_l_reg : a_l_reg;
    assign dr = src_sel_reg ? b_r_reg : a_r_reg;
    assign take_l = (l_reg < mid_reg) && (!(r_reg < hi_reg) || (dl < dr));
    assign lo_step   = lo_reg + (width_reg << 1);
    assign width_dbl = width_reg << 1;
    assign mid_raw   = lo_reg + width_reg;
    assign hi_raw    = lo_step;

    always_comb
    begin
        if (state_reg == ST_EMIT_RD || state_reg == ST_EMIT)
        begin
            rd_l_addr = emit_cnt_reg[IW-1:0];
        end
        else
        begin
            rd_l_addr = to_idx(l_reg);
        end
        rd_r_addr = to_idx(r_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        src_sel_next  = src_sel_reg;
        width_next    = width_reg;
        lo_next       = lo_reg;
        mid_next      = mid_reg;
        hi_next       = hi_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        out_next      = out_reg;
        load_cnt_next = load_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        q_pop         = 1'b0;
        oq_push       = 1'b0;
        oq_item.value = dl;
        oq_item.last  = (emit_cnt_reg == bums_pkg::LAST_CNT);
        wr_a          = 1'b0;
        wr_b          = 1'b0;
        wr_addr       = to_idx(out_reg);
        wr_data       = take_l ? dl : dr;

        unique case (state_reg)
            ST_LOAD:
            begin
                wr_addr = load_cnt_reg[IW-1:0];
                wr_data = q_data;
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    wr_a  = 1'b1;
                    if (load_cnt_reg == bums_pkg::LAST_CNT)
                    begin
                        load_cnt_next = '0;
                        src_sel_next  = 1'b0;
                        width_next    = SW'(1);
                        lo_next       = '0;
                        out_next      = '0;
                        state_next    = ST_SETUP;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + CW'(1);
                    end
                end
            end
            ST_SETUP:
            begin
                mid_next   = (mid_raw > bums_pkg::N_SPAN) ? bums_pkg::N_SPAN : mid_raw;
                hi_next    = (hi_raw > bums_pkg::N_SPAN) ? bums_pkg::N_SPAN : hi_raw;
                l_next     = lo_reg;
                r_next     = (mid_raw > bums_pkg::N_SPAN) ? bums_pkg::N_SPAN : mid_raw;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                wr_a     = src_sel_reg;
                wr_b     = !src_sel_reg;
                out_next = out_reg + SW'(1);
                if (take_l)
                begin
                    l_next = l_reg + SW'(1);
                end
                else
                begin
                    r_next = r_reg + SW'(1);
                end
                if (out_reg + SW'(1) == hi_reg)
                begin
                    if (lo_step >= bums_pkg::N_SPAN)
                    begin
                        width_next   = width_dbl;
                        src_sel_next = !src_sel_reg;
                        lo_next      = '0;
                        out_next     = '0;
                        if (width_dbl >= bums_pkg::N_SPAN)
                        begin
                            emit_cnt_next = '0;
                            state_next    = ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = ST_SETUP;
                        end
                    end
                    else
                    begin
                        lo_next    = lo_step;
                        state_next = ST_SETUP;
                    end
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!oq_full)
                begin
                    oq_push = 1'b1;
                    if (emit_cnt_reg == bums_pkg::LAST_CNT)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        emit_cnt_next = emit_cnt_reg + CW'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            emit_cnt_reg <= '0;
            src_sel_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            src_sel_reg  <= src_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        a_l_reg <= mem_a[rd_l_addr];
        a_r_reg <= mem_a[rd_r_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            mem_b[wr_addr] <= wr_data;
        end
        b_l_reg <= mem_b[rd_l_addr];
        b_r_reg <= mem_b[rd_r_addr];
    end

endmodule

// ----- hw/rtl/bums_checker.sv -----
// ----------------------------------------------------------------------------
// Sorter port checker
// Watches the ports of the sorter for reset state, held results, ordering and block framing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bums_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            full,
    input logic            empty,
    input logic            pop,
    input bums_pkg::data_t sorted_value,
    input logic            last
);

    logic                         take;
    logic                         prev_valid_reg;
    bums_pkg::data_t              prev_reg;
    logic [bums_pkg::CNT_W-1:0]   cnt_reg;

    assign take = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else if (take)
        begin
            prev_valid_reg <= !last;
            cnt_reg        <= last ? '0 : cnt_reg + bums_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prev_reg <= sorted_value;
        end
    end

    `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (empty && !full))
    `ASSERT_CLK(a_result_held, (!empty && !pop) |=> (!empty && $stable(sorted_value) && $stable(last)))
    `ASSERT_CLK(a_ascending, (take && prev_valid_reg) |-> (sorted_value >= prev_reg))
    `ASSERT_CLK(a_block_frame, take |-> (last == (cnt_reg == bums_pkg::LAST_CNT)))

endmodule

bind bottom_up_merge_sorter bums_checker u_bums_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .sorted_value (sorted_value),
    .last         (last)
);
